@@ design/lde_pkg.sv @@
// ----------------------------------------------------------------------------
// lde_pkg: shared types and constants for the line diff edit distance block
// Sizes of the token stores, the cost grid and the command codes.
// ----------------------------------------------------------------------------
package lde_pkg;

    localparam int MAX_LINES  = 32;
    localparam int TOKEN_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_LINES);
    localparam int CNT_W      = $clog2(MAX_LINES + 1);
    localparam int GRID_SIDE  = MAX_LINES + 1;
    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int COST_W     = 7;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

endpackage

@@ design/lde_ram.sv @@
// ----------------------------------------------------------------------------
// lde_ram: generic single-port RAM
// Reads and writes share the one address i_addr; the read data is registered, and on a write it holds the old word.
// ----------------------------------------------------------------------------
module lde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ design/line_diff_edit_distance.sv @@
// ----------------------------------------------------------------------------
// line_diff_edit_distance: insert/delete edit distance between token sequences
// Fills the cost grid cell by cell, traces back, and reports per-line flags.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  input    | in        | i_valid, o_ready, i_command, i_token
//  result   | out       | o_valid, i_ready, o_which_sequence .. o_last_result
//
// A load is taken in S_IDLE. A run fills the grid cell by cell: S_F_TOK, then the
// states that read the neighbouring costs it needs (S_F_RL, S_F_RU, S_F_RD, and
// S_T_DIST on a match), then S_F_WR; the traceback steps through S_T_RH, S_T_RL,
// S_T_RU and S_T_DEC, then S_OUT reports one line per accepted result, held by
// output stalls. Every cost goes through one grid RAM port. Reset clears the
// counts, the overflow flag, o_valid and the sequencer. The block takes no item
// until the last result of a run has been accepted.
module line_diff_edit_distance (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic [31:0]               i_token,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_which_sequence,
    output logic [4:0]                o_line_index,
    output logic                      o_line_present,
    output logic                      o_unchanged,
    output logic [6:0]                o_distance,
    output logic                      o_overflowed,
    output logic                      o_last_result
);
    import lde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_F_TOK, S_F_RL, S_F_RU, S_F_RD, S_F_WR,
        S_T_RH, S_T_RL, S_T_RU, S_T_DEC, S_T_DIST, S_OUT
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_a_count, r_b_count, r_x, r_y;
    logic r_ovf;
    logic [COST_W-1:0] r_best, r_here, r_left, r_dist;
    logic r_match;
    logic r_a_same [MAX_LINES];
    logic r_b_same [MAX_LINES];
    logic r_out_seq;
    logic [IDX_W-1:0] r_out_idx;
    logic r_out_present;

    // Token stores and grid.
    logic tok_we_a, tok_we_b;
    logic [IDX_W-1:0] a_addr, b_addr;
    logic [TOKEN_BITS-1:0] a_rd, b_rd;
    logic g_we;
    logic [GRID_AW-1:0] g_addr;
    logic [COST_W-1:0] g_wd, g_rd;

    lde_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LINES)) u_a_ram (
        .i_clk(i_clk), .i_we(tok_we_a), .i_addr(a_addr),
        .i_wdata(i_token[TOKEN_BITS-1:0]), .o_rdata(a_rd));
    lde_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LINES)) u_b_ram (
        .i_clk(i_clk), .i_we(tok_we_b), .i_addr(b_addr),
        .i_wdata(i_token[TOKEN_BITS-1:0]), .o_rdata(b_rd));
    lde_ram #(.WIDTH(COST_W), .DEPTH(GRID_DEPTH)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_addr(g_addr),
        .i_wdata(g_wd), .o_rdata(g_rd));

    logic accept;
    t_cmd cmd;
    assign cmd    = t_cmd'(i_command);
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    assign tok_we_a = accept && cmd == CMD_LOAD_A && r_a_count < CNT_W'(MAX_LINES);
    assign tok_we_b = accept && cmd == CMD_LOAD_B && r_b_count < CNT_W'(MAX_LINES);

    logic [IDX_W-1:0] xm1, ym1;
    assign xm1 = IDX_W'(r_x - 1'b1);
    assign ym1 = IDX_W'(r_y - 1'b1);
    assign a_addr = (r_state == S_IDLE) ? IDX_W'(r_a_count) : xm1;
    assign b_addr = (r_state == S_IDLE) ? IDX_W'(r_b_count) : ym1;

    // Grid address: one shared multiply-add on the chosen coordinates.
    logic [CNT_W-1:0] gx, gy;
    always_comb begin
        gx = r_x;
        gy = r_y;
        unique case (r_state)
            S_F_RL, S_T_RL: gx = r_x - 1'b1;
            S_F_RU, S_T_RU: gy = r_y - 1'b1;
            S_F_RD: begin
                gx = r_x - 1'b1;
                gy = r_y - 1'b1;
            end
            default: ;
        endcase
    end
    assign g_addr = GRID_AW'(GRID_AW'(gy) * GRID_AW'(GRID_SIDE) + GRID_AW'(gx));
    assign g_we   = (r_state == S_F_WR);
    assign g_wd   = r_best;

    logic [COST_W-1:0] g_inc;
    assign g_inc = g_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a_count <= '0;
            r_b_count <= '0;
            r_ovf     <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept) begin
                    unique case (cmd)
                        CMD_LOAD_A: if (tok_we_a) r_a_count <= r_a_count + 1'b1;
                                    else r_ovf <= 1'b1;
                        CMD_LOAD_B: if (tok_we_b) r_b_count <= r_b_count + 1'b1;
                                    else r_ovf <= 1'b1;
                        CMD_RUN: begin
                            r_x <= '0;
                            r_y <= '0;
                            r_state <= S_F_TOK;
                        end
                        default: ;
                    endcase
                end
                // Token reads for (x, y) are issued by the address in this state.
                S_F_TOK: begin
                    r_best  <= (r_x == '0 && r_y == '0) ? '0 : 7'd127;
                    r_state <= (r_x == '0 && r_y == '0) ? S_F_WR
                             : (r_x != '0) ? S_F_RL : S_F_RU;
                end
                S_F_RL: begin
                    r_match <= (r_x != '0 && r_y != '0 && a_rd == b_rd);
                    r_state <= S_F_RU;
                end
                S_F_RU: begin
                    // Left cost has arrived when coming from S_F_RL.
                    if (r_x != '0) r_best <= g_inc;
                    if (r_x == '0) r_match <= 1'b0;
                    r_state <= (r_y != '0) ? S_F_RD : S_F_WR;
                end
                S_F_RD: begin
                    if (g_inc < r_best) r_best <= g_inc;
                    r_here  <= (g_inc < r_best) ? g_inc : r_best;
                    r_state <= r_match ? S_T_DIST : S_F_WR;
                end
                S_T_DIST: begin
                    // Diagonal cost on a match.
                    if (g_rd < r_here) r_best <= g_rd;
                    else r_best <= r_here;
                    r_state <= S_F_WR;
                end
                S_F_WR: begin
                    if (r_x == r_a_count && r_y == r_b_count) begin
                        r_dist  <= r_best;
                        r_state <= S_T_RH;
                    end else if (r_x == r_a_count) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                        r_state <= S_F_TOK;
                    end else begin
                        r_x <= r_x + 1'b1;
                        r_state <= S_F_TOK;
                    end
                end
                S_T_RH: begin
                    if (r_x == '0 && r_y == '0) begin
                        // Reporting starts with A lines, or B lines when A is empty.
                        if (r_a_count != '0 || r_b_count != '0) begin
                            r_out_seq     <= (r_a_count == '0);
                            r_out_present <= 1'b1;
                        end else begin
                            r_out_seq     <= 1'b0;
                            r_out_present <= 1'b0;
                        end
                        r_out_idx <= '0;
                        o_valid   <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_T_RL;
                    end
                end
                S_T_RL: begin
                    r_here  <= g_rd;
                    r_state <= S_T_RU;
                end
                S_T_RU: begin
                    r_left  <= g_rd;
                    r_state <= S_T_DEC;
                end
                S_T_DEC: begin
                    if (r_x != '0 && r_left + 1'b1 == r_here) begin
                        r_a_same[xm1] <= 1'b0;
                        r_x <= r_x - 1'b1;
                    end else if (r_y != '0 && g_inc == r_here) begin
                        r_b_same[ym1] <= 1'b0;
                        r_y <= r_y - 1'b1;
                    end else begin
                        if (r_x != '0) begin
                            r_a_same[xm1] <= 1'b1;
                            r_x <= r_x - 1'b1;
                        end
                        if (r_y != '0) begin
                            r_b_same[ym1] <= 1'b1;
                            r_y <= r_y - 1'b1;
                        end
                    end
                    r_state <= S_T_RH;
                end
                S_OUT: if (i_ready) begin
                    if (o_last_result) begin
                        o_valid   <= 1'b0;
                        r_a_count <= '0;
                        r_b_count <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end else if (!r_out_seq && CNT_W'(r_out_idx) + 1'b1 == r_a_count) begin
                        r_out_seq <= 1'b1;
                        r_out_idx <= '0;
                    end else begin
                        r_out_idx <= r_out_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_F_RD with a match goes on to S_T_DIST for the diagonal cost,
    // and then to S_F_WR.
    assign o_which_sequence = r_out_seq;
    assign o_line_index     = 5'(r_out_idx);
    assign o_line_present   = r_out_present;
    assign o_unchanged      = !r_out_present ? 1'b0
                            : (r_out_seq ? r_b_same[r_out_idx] : r_a_same[r_out_idx]);
    assign o_distance       = r_dist;
    assign o_overflowed     = r_ovf;
    assign o_last_result    = !r_out_present
                            || (r_out_seq ? (CNT_W'(r_out_idx) + 1'b1 == r_b_count)
                                          : (CNT_W'(r_out_idx) + 1'b1 == r_a_count
                                             && r_b_count == '0));
endmodule

@@ design/lde_checker.sv @@
// ----------------------------------------------------------------------------
// lde_checker: port-level checks for line_diff_edit_distance
// Watches the handshakes and the result stream of a run.
// ----------------------------------------------------------------------------
module lde_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_last_result,
    input logic       o_line_present,
    input logic [6:0] o_distance
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input taken while results pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_dist_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) |-> $stable(o_distance))
        else $error("distance changed within a run");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_present |-> o_last_result)
        else $error("empty run not final");
endmodule

bind line_diff_edit_distance lde_checker u_lde_checker (.*);

@@ sim/line_diff_edit_distance_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_diff_edit_distance_test: self-checking bench for the line diff block
// Builds sequences of tokens, runs diffs, predicts the per-line flags and the
// distance in the bench, and checks every output transaction in order.
// ----------------------------------------------------------------------------
module line_diff_edit_distance_test;
    import lde_pkg::*;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] token;
    } t_load;

    typedef struct packed {
        logic       which_sequence;
        logic [4:0] line_index;
        logic       line_present;
        logic       unchanged;
        logic [6:0] distance;
        logic       overflowed;
        logic       last_result;
    } t_flag;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_NONE;
    logic [31:0] i_token = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_which_sequence;
    logic [4:0]  o_line_index;
    logic        o_line_present;
    logic        o_unchanged;
    logic [6:0]  o_distance;
    logic        o_overflowed;
    logic        o_last_result;

    line_diff_edit_distance dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_load       pending_loads[$];
    t_flag       expected_flags[$];
    logic [31:0] seq_a[MAX_LINES];
    logic [31:0] seq_b[MAX_LINES];
    int          len_a, len_b;
    bit          dropped;
    int          cost[GRID_SIDE][GRID_SIDE];
    bit          same_a[MAX_LINES];
    bit          same_b[MAX_LINES];
    int          errors = 0;
    bit          stimulus_done = 0;

    // Predicts the effect of one accepted transaction on the sequences and, on a run, the results.
    task automatic predict_diff(input t_load ld);
        int x, y, d, total;
        t_flag f;
        begin
            if (ld.command == CMD_LOAD_A || ld.command == CMD_LOAD_B) begin
                if (ld.command == CMD_LOAD_A) begin
                    if (len_a >= MAX_LINES) dropped = 1;
                    else begin seq_a[len_a] = ld.token; len_a++; end
                end else begin
                    if (len_b >= MAX_LINES) dropped = 1;
                    else begin seq_b[len_b] = ld.token; len_b++; end
                end
            end else if (ld.command == CMD_RUN) begin
                for (y = 0; y <= len_b; y++) begin
                    for (x = 0; x <= len_a; x++) begin
                        if (x == 0 && y == 0) begin
                            cost[0][0] = 0;
                        end else begin
                            d = 255;
                            if (x > 0 && cost[x-1][y] + 1 < d) d = cost[x-1][y] + 1;
                            if (y > 0 && cost[x][y-1] + 1 < d) d = cost[x][y-1] + 1;
                            if (x > 0 && y > 0 && seq_a[x-1] == seq_b[y-1]
                                && cost[x-1][y-1] < d) d = cost[x-1][y-1];
                            cost[x][y] = d;
                        end
                    end
                end
                // Traceback prefers dropping an A line, then a B line.
                x = len_a;
                y = len_b;
                while (x != 0 || y != 0) begin
                    if (x > 0 && cost[x-1][y] + 1 == cost[x][y]) begin
                        same_a[x-1] = 0; x--;
                    end else if (y > 0 && cost[x][y-1] + 1 == cost[x][y]) begin
                        same_b[y-1] = 0; y--;
                    end else begin
                        if (x > 0) begin same_a[x-1] = 1; x--; end
                        if (y > 0) begin same_b[y-1] = 1; y--; end
                    end
                end
                d = cost[len_a][len_b];
                total = len_a + len_b;
                f.distance = d[6:0];
                f.overflowed = dropped;
                if (total == 0) begin
                    f.which_sequence = 0;
                    f.line_index = 0;
                    f.line_present = 0;
                    f.unchanged = 0;
                    f.last_result = 1;
                    expected_flags.push_back(f);
                end else begin
                    for (x = 0; x < len_a + len_b; x++) begin
                        f.which_sequence = (x >= len_a);
                        f.line_index = 5'((x >= len_a) ? x - len_a : x);
                        f.line_present = 1;
                        f.unchanged = (x >= len_a) ? same_b[x-len_a] : same_a[x];
                        f.last_result = (x + 1 == total);
                        expected_flags.push_back(f);
                    end
                end
                len_a = 0;
                len_b = 0;
                dropped = 0;
            end
        end
    endtask

    // Sender: bursts of transactions separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_diff(t_load'({t_cmd'(i_command), i_token}));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_loads.size() > 0) begin
                t_load ld;
                ld = pending_loads.pop_front();
                i_valid <= 1'b1;
                i_command <= ld.command;
                i_token <= ld.token;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, with stall-free stretches.
    int rx_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_phase <= (rx_phase + 1) % 400;
            if (rx_phase < 150) i_ready <= 1'b1;
            else if (rx_phase < 300) i_ready <= ($urandom_range(0, 3) != 0);
            else i_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // Monitor and watchdog.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_flags.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    t_flag e;
                    e = expected_flags.pop_front();
                    if (o_which_sequence !== e.which_sequence) begin
                        $error("which_sequence: expected %0d got %0d",
                               e.which_sequence, o_which_sequence); errors++;
                    end
                    if (o_line_index !== e.line_index) begin
                        $error("line_index: expected %0d got %0d",
                               e.line_index, o_line_index); errors++;
                    end
                    if (o_line_present !== e.line_present) begin
                        $error("line_present: expected %0d got %0d",
                               e.line_present, o_line_present); errors++;
                    end
                    if (o_unchanged !== e.unchanged) begin
                        $error("unchanged: expected %0d got %0d",
                               e.unchanged, o_unchanged); errors++;
                    end
                    if (o_distance !== e.distance) begin
                        $error("distance: expected %0d got %0d",
                               e.distance, o_distance); errors++;
                    end
                    if (o_overflowed !== e.overflowed) begin
                        $error("overflowed: expected %0d got %0d",
                               e.overflowed, o_overflowed); errors++;
                    end
                    if (o_last_result !== e.last_result) begin
                        $error("last_result: expected %0d got %0d",
                               e.last_result, o_last_result); errors++;
                    end
                end
            end
        end
    end

    function automatic t_load mk(input t_cmd c, input logic [31:0] t);
        mk.command = c;
        mk.token = t;
    endfunction

    // Token drawn from a small alphabet so that lines often match.
    function automatic logic [31:0] pick_token(input int alphabet);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, alphabet);
        return $urandom_range(0, alphabet);
    endfunction

    task automatic queue_diff(input int na, input int nb, input int alphabet);
        int i;
        begin
            for (i = 0; i < na; i++) pending_loads.push_back(mk(CMD_LOAD_A, pick_token(alphabet)));
            for (i = 0; i < nb; i++) pending_loads.push_back(mk(CMD_LOAD_B, pick_token(alphabet)));
            pending_loads.push_back(mk(CMD_RUN, $urandom));
        end
    endtask

    initial begin
        int i, k, na, nb, count;
        len_a = 0;
        len_b = 0;
        dropped = 0;
        // Directed: empty run, one-sided runs, swapped and identical lines.
        pending_loads.push_back(mk(CMD_RUN, 32'hFFFF_FFFF));
        pending_loads.push_back(mk(CMD_NONE, 32'h1234_5678));
        pending_loads.push_back(mk(CMD_LOAD_A, 32'h0000_0000));
        pending_loads.push_back(mk(CMD_RUN, 0));
        pending_loads.push_back(mk(CMD_LOAD_B, 32'hFFFF_FFFF));
        pending_loads.push_back(mk(CMD_RUN, 0));
        pending_loads.push_back(mk(CMD_LOAD_A, 32'hAAAA_5555));
        pending_loads.push_back(mk(CMD_LOAD_A, 32'h5555_AAAA));
        pending_loads.push_back(mk(CMD_LOAD_B, 32'h5555_AAAA));
        pending_loads.push_back(mk(CMD_LOAD_B, 32'hAAAA_5555));
        pending_loads.push_back(mk(CMD_NONE, 0));
        pending_loads.push_back(mk(CMD_RUN, 0));
        pending_loads.push_back(mk(CMD_LOAD_A, 32'h8000_0001));
        pending_loads.push_back(mk(CMD_LOAD_B, 32'h8000_0001));
        pending_loads.push_back(mk(CMD_RUN, 0));
        // Full sequences plus overflow on both sides.
        for (i = 0; i < MAX_LINES + 2; i++) pending_loads.push_back(mk(CMD_LOAD_A, i % 5));
        for (i = 0; i < MAX_LINES + 1; i++) pending_loads.push_back(mk(CMD_LOAD_B, i % 7));
        pending_loads.push_back(mk(CMD_RUN, 0));
        // Random diffs, mostly small, a few at capacity.
        count = 0;
        while (count < 195) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                na = MAX_LINES; nb = $urandom_range(MAX_LINES - 2, MAX_LINES + 2);
            end else begin
                na = $urandom_range(0, 8); nb = $urandom_range(0, 8);
            end
            queue_diff(na, nb, $urandom_range(1, 6));
            if ($urandom_range(0, 9) == 0) pending_loads.push_back(mk(CMD_NONE, $urandom));
            count += na + nb + 1;
        end
        pending_loads.push_back(mk(CMD_RUN, 0));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_loads.size() == 0 && !i_valid);
        wait (expected_flags.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_flags.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
